@@ hw/rtl/htwd_pkg.sv @@
package htwd_pkg;

  localparam int IDX_W         = 10;
  localparam int SYM_W         = 8;
  localparam int CODE_W        = 8;
  localparam int KIND_W        = 2;
  localparam int CMD_W         = 2;
  localparam int BIT_CNT_W     = 3;
  localparam int APB_DW        = 32;
  localparam int APB_AW        = 3;
  localparam int TABLE_DEPTH_D = 1024;

  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

  localparam logic [KIND_W-1:0] KIND_INTERNAL = 2'd0;
  localparam logic [KIND_W-1:0] KIND_SYMBOL   = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END      = 2'd2;

  localparam logic RES_SYMBOL = 1'b0;
  localparam logic RES_END    = 1'b1;

  // word index of a register, taken from paddr[APB_AW-1]
  localparam logic REG_ROOT_NODE = 1'b0;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [SYM_W-1:0]  sym;
    logic [IDX_W-1:0]  left;
    logic [IDX_W-1:0]  right;
  } node_entry_t;

  localparam int ENTRY_W = $bits(node_entry_t);

endpackage

@@ hw/rtl/htwd_if.sv @@
interface htwd_cmd_if
  import htwd_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [IDX_W-1:0]  node_index;
  logic [KIND_W-1:0] node_kind;
  logic [SYM_W-1:0]  node_symbol;
  logic [IDX_W-1:0]  left_child;
  logic [IDX_W-1:0]  right_child;
  logic [CODE_W-1:0] code_byte;

  modport source (
    output valid, command, node_index, node_kind, node_symbol,
           left_child, right_child, code_byte,
    input  ready
  );

  modport sink (
    input  valid, command, node_index, node_kind, node_symbol,
           left_child, right_child, code_byte,
    output ready
  );
endinterface

interface htwd_res_if
  import htwd_pkg::*;
;
  logic             valid;
  logic             ready;
  logic             result_kind;
  logic [SYM_W-1:0] symbol;
  logic             last;

  modport source (
    output valid, result_kind, symbol, last,
    input  ready
  );

  modport sink (
    input  valid, result_kind, symbol, last,
    output ready
  );
endinterface

@@ hw/rtl/htwd_ram.sv @@
module htwd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr_a,
  output logic [WIDTH-1:0] rdata_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

@@ hw/rtl/huffman_tree_walk_decoder.sv @@
// Huffman tree-walk decoder. Load, start and ignored commands are taken in the idle state.
// Decode: one node-table read per code bit; each code byte goes through accept, entry fetch,
// eight walk steps and flush, with fewer walk steps when the end leaf is reached.
// Each result waits in a holding register until the next one or the flush; a full
// output register stalls the walk. Synchronous reset clears walk position, finished
// flag, root register and handshakes; the node table is not cleared.
module huffman_tree_walk_decoder
  import htwd_pkg::*;
#(
  parameter int TABLE_DEPTH = TABLE_DEPTH_D
) (
  input  logic              clk,
  input  logic              rst,
  htwd_cmd_if.sink          cmd,
  htwd_res_if.source        res,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [IDX_W:0] DEPTH_LIM = (IDX_W+1)'(TABLE_DEPTH);

  typedef enum logic [1:0] {S_IDLE, S_FETCH, S_CHECK, S_FLUSH} state_t;

  state_t              state;
  logic [IDX_W-1:0]    root_node;
  logic [IDX_W-1:0]    walk_pos;
  logic                finished;
  logic [CODE_W-1:0]   byte_reg;
  logic [BIT_CNT_W-1:0] bit_cnt;
  logic [IDX_W-1:0]    rd_addr;
  logic [IDX_W-1:0]    rd_addr_next;
  logic                pend_valid;
  logic                pend_kind;
  logic [SYM_W-1:0]    pend_sym;
  logic                out_valid;
  logic                out_kind;
  logic [SYM_W-1:0]    out_sym;
  logic                out_last;

  logic [ENTRY_W-1:0]  rdata_a;
  logic [ENTRY_W-1:0]  rdata_b;
  node_entry_t         entry_a;
  node_entry_t         entry_root;
  node_entry_t         base;
  node_entry_t         wentry;
  logic                rd_oob;
  logic                root_oob;
  logic                idx_ok;
  logic                cmd_acc;
  logic                we;
  logic                out_free;
  logic                out_load;
  logic                is_result;
  logic                stall;
  logic [IDX_W-1:0]    child;
  logic                cfg_wr;

  assign cfg_wr = psel && penable && pwrite && (paddr[APB_AW-1] == REG_ROOT_NODE);
  assign pready = 1'b1;
  assign prdata = (paddr[APB_AW-1] == REG_ROOT_NODE) ?
                  {{(APB_DW-IDX_W){1'b0}}, root_node} : '0;

  assign cmd.ready = (state == S_IDLE);
  assign cmd_acc   = cmd.valid && cmd.ready;
  assign idx_ok    = {1'b0, cmd.node_index} < DEPTH_LIM;
  assign we        = cmd_acc && (cmd.command == CMD_LOAD) && idx_ok;

  assign wentry.kind  = cmd.node_kind;
  assign wentry.sym   = cmd.node_symbol;
  assign wentry.left  = cmd.left_child;
  assign wentry.right = cmd.right_child;

  htwd_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TABLE_DEPTH),
    .AW    (AW)
  ) u_table (
    .clk     (clk),
    .we      (we),
    .waddr   (cmd.node_index[AW-1:0]),
    .wdata   (wentry),
    .raddr_a (rd_addr_next[AW-1:0]),
    .rdata_a (rdata_a),
    .raddr_b (root_node[AW-1:0]),
    .rdata_b (rdata_b)
  );

  assign rd_oob     = !({1'b0, rd_addr} < DEPTH_LIM);
  assign root_oob   = !({1'b0, root_node} < DEPTH_LIM);
  assign entry_a    = rd_oob ? '0 : node_entry_t'(rdata_a);
  assign entry_root = root_oob ? '0 : node_entry_t'(rdata_b);

  assign out_free  = !out_valid || res.ready;
  assign is_result = (entry_a.kind == KIND_SYMBOL) || (entry_a.kind == KIND_END);
  assign stall     = is_result && pend_valid && !out_free;
  assign out_load  = ((state == S_CHECK) && !stall && is_result && pend_valid) ||
                     ((state == S_FLUSH) && pend_valid && out_free);

  // after a symbol leaf the walk restarts from the root entry
  assign base  = ((state == S_CHECK) && (entry_a.kind == KIND_SYMBOL)) ? entry_root : entry_a;
  assign child = byte_reg[CODE_W-1] ? base.right : base.left;

  assign res.valid       = out_valid;
  assign res.result_kind = out_kind;
  assign res.symbol      = out_sym;
  assign res.last        = out_last;

  always_comb begin
    rd_addr_next = rd_addr;
    unique case (state)
      S_IDLE: begin
        if (cmd_acc && (cmd.command == CMD_DECODE) && !finished) begin
          rd_addr_next = walk_pos;
        end
      end
      S_FETCH: begin
        rd_addr_next = child;
      end
      S_CHECK: begin
        if (!stall && (entry_a.kind != KIND_END) && (bit_cnt != '0)) begin
          rd_addr_next = child;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      root_node  <= '0;
      walk_pos   <= '0;
      finished   <= 1'b0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      rd_addr <= rd_addr_next;
      if (cfg_wr) begin
        root_node <= pwdata[IDX_W-1:0];
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (res.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (cmd_acc) begin
            if (cmd.command == CMD_START) begin
              walk_pos <= root_node;
              finished <= 1'b0;
            end else if ((cmd.command == CMD_DECODE) && !finished) begin
              byte_reg <= cmd.code_byte;
              bit_cnt  <= BIT_CNT_W'(CODE_W - 1);
              state    <= S_FETCH;
            end
          end
        end
        S_FETCH: begin
          byte_reg <= {byte_reg[CODE_W-2:0], 1'b0};
          state    <= S_CHECK;
        end
        S_CHECK: begin
          if (!stall) begin
            if (is_result && pend_valid) begin
              out_kind  <= pend_kind;
              out_sym   <= pend_sym;
              out_last  <= 1'b0;
            end
            if (entry_a.kind == KIND_END) begin
              pend_valid <= 1'b1;
              pend_kind  <= RES_END;
              pend_sym   <= '0;
              finished   <= 1'b1;
              walk_pos   <= rd_addr;
              state      <= S_FLUSH;
            end else begin
              if (entry_a.kind == KIND_SYMBOL) begin
                pend_valid <= 1'b1;
                pend_kind  <= RES_SYMBOL;
                pend_sym   <= entry_a.sym;
                walk_pos   <= root_node;
              end else begin
                walk_pos <= rd_addr;
              end
              if (bit_cnt == '0) begin
                state <= S_FLUSH;
              end else begin
                bit_cnt  <= bit_cnt - 1'b1;
                byte_reg <= {byte_reg[CODE_W-2:0], 1'b0};
              end
            end
          end
        end
        S_FLUSH: begin
          if (!pend_valid) begin
            state <= S_IDLE;
          end else if (out_free) begin
            out_kind   <= pend_kind;
            out_sym    <= pend_sym;
            out_last   <= 1'b1;
            pend_valid <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ verif/tb_huffman_tree_walk_decoder.sv @@
`timescale 1ns / 100ps

module tb_huffman_tree_walk_decoder
  import htwd_pkg::*;
;

  localparam logic [CMD_W-1:0]  CMD_UNUSED = 2'd3;
  localparam logic [KIND_W-1:0] KIND_SPARE = 2'd3;
  localparam logic [APB_AW-1:0] ROOT_ADDR  = {REG_ROOT_NODE, 2'b00};
  localparam int ITEM_TARGET   = 460;
  localparam int SETTLE_CYCLES = 16;
  localparam int STALL_LIMIT   = 4000;

  typedef struct packed {
    logic [CMD_W-1:0]  command;
    logic [IDX_W-1:0]  node_index;
    logic [KIND_W-1:0] node_kind;
    logic [SYM_W-1:0]  node_symbol;
    logic [IDX_W-1:0]  left_child;
    logic [IDX_W-1:0]  right_child;
    logic [CODE_W-1:0] code_byte;
  } cmd_txn_t;

  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] sym;
    logic             last;
  } result_t;

  logic clk = 1'b0;
  logic rst;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  htwd_cmd_if cmd_bus ();
  htwd_res_if res_bus ();

  huffman_tree_walk_decoder dut (
    .clk     (clk),
    .rst     (rst),
    .cmd     (cmd_bus),
    .res     (res_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk = ~clk;

  // shadow of the decoder state
  node_entry_t      node_mem [TABLE_DEPTH_D];
  bit               node_written [TABLE_DEPTH_D];
  logic [IDX_W-1:0] written_list [$];
  logic [IDX_W-1:0] walk_pos = '0;
  logic [IDX_W-1:0] root_reg = '0;
  bit               stream_done = 1'b0;
  result_t          due_results [$];

  bit tree_slot [TABLE_DEPTH_D];
  int errors = 0;
  int items_sent = 0;
  int burst_left = 0;
  bit gaps_on = 1'b1;
  int ready_hold = 0;
  logic [1:0] ready_mode = 2'd0;
  int unsigned quiet = 0;

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic void walk_tree(input cmd_txn_t t);
    node_entry_t cur, nxt;
    result_t batch [$];
    result_t r;
    case (t.command)
      CMD_LOAD: begin
        node_mem[t.node_index] = '{t.node_kind, t.node_symbol, t.left_child, t.right_child};
        if (!node_written[t.node_index]) begin
          node_written[t.node_index] = 1'b1;
          written_list = {written_list, t.node_index};
        end
      end
      CMD_START: begin
        walk_pos = root_reg;
        stream_done = 1'b0;
      end
      CMD_DECODE: begin
        if (!stream_done) begin
          for (int b = CODE_W - 1; b >= 0; b--) begin
            cur = node_mem[walk_pos];
            walk_pos = t.code_byte[b] ? cur.right : cur.left;
            nxt = node_mem[walk_pos];
            if (nxt.kind == KIND_END) begin
              r = '{RES_END, '0, 1'b0};
              batch = {batch, r};
              stream_done = 1'b1;
              break;
            end
            if (nxt.kind == KIND_SYMBOL) begin
              r = '{RES_SYMBOL, nxt.sym, 1'b0};
              batch = {batch, r};
              walk_pos = root_reg;
            end
          end
          if (batch.size() > 0) batch[batch.size() - 1].last = 1'b1;
          foreach (batch[i]) due_results = {due_results, batch[i]};
        end
      end
      default: ;
    endcase
  endfunction

  function automatic cmd_txn_t random_txn(input logic [CMD_W-1:0] op);
    cmd_txn_t t;
    t.command     = op;
    t.node_index  = IDX_W'($urandom);
    t.node_kind   = KIND_W'($urandom);
    t.node_symbol = SYM_W'($urandom);
    t.left_child  = IDX_W'($urandom);
    t.right_child = IDX_W'($urandom);
    t.code_byte   = CODE_W'($urandom);
    return t;
  endfunction

  function automatic cmd_txn_t load_txn(input logic [IDX_W-1:0] idx,
                                        input logic [KIND_W-1:0] kind,
                                        input logic [SYM_W-1:0] sym,
                                        input logic [IDX_W-1:0] left,
                                        input logic [IDX_W-1:0] right);
    cmd_txn_t t;
    t = random_txn(CMD_LOAD);
    t.node_index  = idx;
    t.node_kind   = kind;
    t.node_symbol = sym;
    t.left_child  = left;
    t.right_child = right;
    return t;
  endfunction

  function automatic cmd_txn_t decode_txn(input logic [CODE_W-1:0] code);
    cmd_txn_t t;
    t = random_txn(CMD_DECODE);
    t.code_byte = code;
    return t;
  endfunction

  // children only ever point at entries already loaded, or at the entry itself
  function automatic logic [IDX_W-1:0] pick_child(input logic [IDX_W-1:0] self_idx);
    if (written_list.size() == 0 || $urandom_range(0, 3) == 0) return self_idx;
    return written_list[$urandom_range(0, written_list.size() - 1)];
  endfunction

  function automatic logic [IDX_W-1:0] fresh_index();
    logic [IDX_W-1:0] idx;
    do idx = IDX_W'($urandom); while (tree_slot[idx]);
    tree_slot[idx] = 1'b1;
    return idx;
  endfunction

  task automatic send_item(input cmd_txn_t t);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      if (gaps_on) begin
        gap = $urandom_range(1, 6);
        cmd_bus.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    cmd_bus.valid       <= 1'b1;
    cmd_bus.command     <= t.command;
    cmd_bus.node_index  <= t.node_index;
    cmd_bus.node_kind   <= t.node_kind;
    cmd_bus.node_symbol <= t.node_symbol;
    cmd_bus.left_child  <= t.left_child;
    cmd_bus.right_child <= t.right_child;
    cmd_bus.code_byte   <= t.code_byte;
    @(posedge clk);
    while (!cmd_bus.ready) @(posedge clk);
    walk_tree(t);
    items_sent++;
  endtask

  // drain all pending results, then give the walk time to finish silently
  task automatic settle();
    cmd_bus.valid <= 1'b0;
    burst_left = 0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_root(input logic [IDX_W-1:0] root);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ROOT_ADDR;
    pwdata  <= APB_DW'(root);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    root_reg = root;
  endtask

  // random full tree on fresh slots; leaves first, parents after their children
  task automatic grow_tree(input int leaves, input bit with_end,
                           output logic [IDX_W-1:0] top);
    logic [IDX_W-1:0] pool [$];
    logic [IDX_W-1:0] idx, a, b;
    int k;
    foreach (tree_slot[i]) tree_slot[i] = 1'b0;
    for (int i = 0; i < leaves; i++) begin
      idx = fresh_index();
      send_item(load_txn(idx, (with_end && i == 0) ? KIND_END : KIND_SYMBOL,
                         SYM_W'($urandom), pick_child(idx), pick_child(idx)));
      pool = {pool, idx};
    end
    while (pool.size() > 1) begin
      k = $urandom_range(0, pool.size() - 1);
      a = pool[k];
      pool.delete(k);
      k = $urandom_range(0, pool.size() - 1);
      b = pool[k];
      pool.delete(k);
      idx = fresh_index();
      send_item(load_txn(idx, ($urandom_range(0, 7) == 0) ? KIND_SPARE : KIND_INTERNAL,
                         SYM_W'($urandom), a, b));
      pool = {pool, idx};
    end
    top = pool[0];
  endtask

  task automatic test_decode_before_start();
    send_item(load_txn(10'd1, KIND_SYMBOL, 8'hFF, 10'd1, 10'd1));
    send_item(load_txn(10'd2, KIND_END, 8'h00, 10'd2, 10'd2));
    send_item(load_txn(10'd1023, KIND_SYMBOL, 8'h00, 10'd1023, 10'd1023));
    send_item(load_txn(10'd3, KIND_SPARE, 8'hA5, 10'd1023, 10'd2));
    send_item(load_txn(10'd0, KIND_INTERNAL, 8'h5A, 10'd1, 10'd3));
    send_item(decode_txn(8'h00));
    send_item(decode_txn(8'h80));
    send_item(decode_txn(8'hC0));
    send_item(decode_txn(8'hFF));
  endtask

  task automatic test_restart();
    send_item(random_txn(CMD_START));
    send_item(decode_txn(8'h55));
    send_item(decode_txn(8'hFF));
  endtask

  task automatic test_unused_command();
    cmd_txn_t t;
    t = '1;
    t.command = CMD_UNUSED;
    send_item(random_txn(CMD_START));
    send_item(t);
    send_item(decode_txn(8'h00));
  endtask

  task automatic test_root_change();
    send_item(random_txn(CMD_START));
    send_item(decode_txn(8'h01));
    settle();
    write_root(10'd1023);
    send_item(decode_txn(8'h7F));
  endtask

  task automatic test_root_leaf();
    send_item(load_txn(10'd1023, KIND_SYMBOL, 8'h00, 10'd1, 10'd3));
    send_item(random_txn(CMD_START));
    send_item(decode_txn(8'h4B));
    send_item(decode_txn(8'hFF));
    settle();
    write_root(10'd0);
  endtask

  task automatic test_random_streams();
    logic [IDX_W-1:0] top, idx;
    int steps, pick;
    while (items_sent < ITEM_TARGET) begin
      gaps_on = ($urandom_range(0, 3) != 0);
      grow_tree($urandom_range(2, 12), $urandom_range(0, 3) != 0, top);
      settle();
      write_root(top);
      send_item(random_txn(CMD_START));
      steps = $urandom_range(8, 30);
      repeat (steps) begin
        pick = $urandom_range(0, 99);
        if (pick < 6) begin
          send_item(random_txn(CMD_UNUSED));
        end else if (pick < 12) begin
          idx = IDX_W'($urandom);
          send_item(load_txn(idx, KIND_W'($urandom), SYM_W'($urandom),
                             pick_child(idx), pick_child(idx)));
        end else if (pick < 15 || (stream_done && pick < 70)) begin
          send_item(random_txn(CMD_START));
        end else if (pick < 17) begin
          settle();
        end else begin
          send_item(decode_txn(CODE_W'($urandom)));
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (ready_hold == 0) begin
      ready_mode <= 2'($urandom_range(0, 3));
      ready_hold <= $urandom_range(16, 96);
    end else begin
      ready_hold <= ready_hold - 1;
    end
    case (ready_mode)
      2'd0: res_bus.ready <= 1'b1;
      2'd1: res_bus.ready <= ($urandom_range(0, 3) != 0);
      2'd2: res_bus.ready <= ($urandom_range(0, 3) == 0);
      default: res_bus.ready <= (ready_hold[1:0] != 2'd0);
    endcase
  end

  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (due_results.size() == 0) begin
        note_error($sformatf("unexpected result: kind %0d sym %02h last %0d",
                             res_bus.result_kind, res_bus.symbol, res_bus.last));
      end else begin
        want = due_results.pop_front();
        if (res_bus.result_kind !== want.kind || res_bus.symbol !== want.sym ||
            res_bus.last !== want.last)
          note_error($sformatf({"result mismatch: expected kind %0d sym %02h last %0d,",
                                " got kind %0d sym %02h last %0d"},
                               want.kind, want.sym, want.last,
                               res_bus.result_kind, res_bus.symbol, res_bus.last));
      end
    end
  end

  always @(posedge clk)
    quiet <= ((cmd_bus.valid && cmd_bus.ready) || (res_bus.valid && res_bus.ready)) ?
             0 : quiet + 1;

  initial begin : watchdog
    wait (quiet >= STALL_LIMIT);
    $display("tb_huffman_tree_walk_decoder: errors");
    $finish;
  end

  initial begin
    rst                 <= 1'b1;
    cmd_bus.valid       <= 1'b0;
    cmd_bus.command     <= CMD_LOAD;
    cmd_bus.node_index  <= '0;
    cmd_bus.node_kind   <= KIND_INTERNAL;
    cmd_bus.node_symbol <= '0;
    cmd_bus.left_child  <= '0;
    cmd_bus.right_child <= '0;
    cmd_bus.code_byte   <= '0;
    psel                <= 1'b0;
    penable             <= 1'b0;
    pwrite              <= 1'b0;
    paddr               <= '0;
    pwdata              <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    test_decode_before_start();
    test_restart();
    test_unused_command();
    test_root_change();
    test_root_leaf();
    test_random_streams();
    settle();
    if (errors == 0) begin
      $display("tb_huffman_tree_walk_decoder: clean");
    end else begin
      $display("tb_huffman_tree_walk_decoder: errors");
    end
    $finish;
  end

endmodule
